/* hdl/ecpa_pkg.sv */
package ecpa_pkg;
  localparam int FIELD_BITS = 7;
  localparam int FW = FIELD_BITS;
  localparam logic [FW-1:0] PRIME = {FW{1'b1}};
  localparam logic [FW-1:0] INV_EXP = PRIME - FW'(2);
  localparam int EXP_CNT_W = $clog2(FW + 1);

  // ALU operand select
  typedef enum logic [3:0] {
    SRC_ZERO, SRC_X1, SRC_Y1, SRC_X2, SRC_Y2, SRC_T0, SRC_T1, SRC_M, SRC_R
  } src_t;

  // destination of an ALU result
  typedef enum logic [2:0] {
    DST_NONE, DST_T0, DST_T1, DST_M, DST_R, DST_X3, DST_Y3
  } dst_t;

  typedef enum logic [1:0] {
    OP_MUL, OP_ADD, OP_SUB
  } op_t;

  // how the result is formed: computed, take first, take second, infinity
  typedef enum logic [1:0] {
    K_CALC, K_P, K_Q, K_INF
  } kind_t;

  typedef struct packed {
    logic load;
    logic step;
    op_t  op;
    src_t src_a;
    src_t src_b;
    dst_t dst;
    logic r_one;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic inf1;
    logic inf2;
    logic x_eq;
    logic y_dbl_ok;
  } dp_stat_t;

  function automatic logic [FW-1:0] fold1(input logic [FW:0] t);
    logic [FW:0] s;
    s = {1'b0, t[FW-1:0]} + {{FW{1'b0}}, t[FW]};
    if (s[FW-1:0] == PRIME) return '0;
    return s[FW-1:0];
  endfunction

  function automatic logic [FW-1:0] canon(input logic [FW-1:0] v);
    return (v == PRIME) ? '0 : v;
  endfunction
endpackage

/* hdl/ecpa_datapath.sv */
module ecpa_datapath
  import ecpa_pkg::*;
(
  input  logic          clk,
  input  dp_cmd_t       cmd,
  input  logic [FW-1:0] p_x,
  input  logic [FW-1:0] p_y,
  input  logic          p_at_infinity,
  input  logic [FW-1:0] q_x,
  input  logic [FW-1:0] q_y,
  input  logic          q_at_infinity,
  input  logic [FW-1:0] curve_a,
  output dp_stat_t      stat,
  output logic [FW-1:0] x1_o,
  output logic [FW-1:0] y1_o,
  output logic [FW-1:0] x2_o,
  output logic [FW-1:0] y2_o,
  output logic [FW-1:0] x3_o,
  output logic [FW-1:0] y3_o
);
  logic [FW-1:0] x1, y1, x2, y2, t0, t1, m, r, x3, y3;
  logic inf1, inf2;
  // shift-and-add multiplier
  logic [FW-1:0] acc, mcand, mplier;
  logic [EXP_CNT_W-1:0] bit_cnt;
  logic busy_mul;
  logic [FW-1:0] op_a, op_b, res;
  logic [FW-1:0] dbl, acc_add;

  function automatic logic [FW-1:0] pick(input src_t s, input logic [FW-1:0] x1v,
      input logic [FW-1:0] y1v, input logic [FW-1:0] x2v, input logic [FW-1:0] y2v,
      input logic [FW-1:0] t0v, input logic [FW-1:0] t1v, input logic [FW-1:0] mv,
      input logic [FW-1:0] rv);
    case (s)
      SRC_X1:  return x1v;
      SRC_Y1:  return y1v;
      SRC_X2:  return x2v;
      SRC_Y2:  return y2v;
      SRC_T0:  return t0v;
      SRC_T1:  return t1v;
      SRC_M:   return mv;
      SRC_R:   return rv;
      default: return '0;
    endcase
  endfunction

  assign op_a = pick(cmd.src_a, x1, y1, x2, y2, t0, t1, m, r);
  assign op_b = pick(cmd.src_b, x1, y1, x2, y2, t0, t1, m, r);

  // doubling mod Mersenne prime is a rotate
  assign dbl = fold1({1'b0, acc[FW-2:0], acc[FW-1]});
  assign acc_add = mplier[FW-1] ? fold1({1'b0, dbl} + {1'b0, mcand}) : dbl;

  always_comb begin
    res = acc;
    case (cmd.op)
      OP_ADD: res = fold1({1'b0, op_a} + {1'b0, op_b});
      OP_SUB: res = fold1({1'b0, op_a} + {1'b0, canon(~op_b)});
      default: res = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x1 <= canon(p_x);
      y1 <= canon(p_y);
      x2 <= canon(q_x);
      y2 <= canon(q_y);
      inf1 <= p_at_infinity;
      inf2 <= q_at_infinity;
      t1 <= canon(curve_a);
    end
    if (cmd.r_one) r <= {{(FW-1){1'b0}}, 1'b1};
    if (cmd.load) begin
      busy_mul <= 1'b0;
    end else if (cmd.step && cmd.op == OP_MUL && !busy_mul) begin
      acc <= '0;
      mcand <= op_a;
      mplier <= op_b;
      bit_cnt <= '0;
      busy_mul <= 1'b1;
    end else if (busy_mul) begin
      // hold the product so it can be written back
      if (bit_cnt == EXP_CNT_W'(FW)) begin
        busy_mul <= 1'b0;
      end else begin
        acc <= acc_add;
        mplier <= {mplier[FW-2:0], 1'b0};
        bit_cnt <= bit_cnt + 1'b1;
      end
    end
    if (cmd.step && (cmd.op != OP_MUL || (busy_mul && bit_cnt == EXP_CNT_W'(FW)))) begin
      case (cmd.dst)
        DST_T0: t0 <= res;
        DST_T1: t1 <= res;
        DST_M:  m <= res;
        DST_R:  r <= res;
        DST_X3: x3 <= res;
        DST_Y3: y3 <= res;
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.done = cmd.op != OP_MUL || (busy_mul && bit_cnt == EXP_CNT_W'(FW));
    stat.inf1 = inf1;
    stat.inf2 = inf2;
    stat.x_eq = x1 == x2;
    stat.y_dbl_ok = (y1 == y2) && (y1 != '0);
  end

  assign x1_o = x1;
  assign y1_o = y1;
  assign x2_o = x2;
  assign y2_o = y2;
  assign x3_o = x3;
  assign y3_o = y3;
endmodule

/* hdl/ecpa_ctrl.sv */
module ecpa_ctrl
  import ecpa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     fin,
  output kind_t    fin_kind
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEC  = 5'b00010,
    S_RUN  = 5'b00100,
    S_EXP  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [4:0] pc, pc_next;
  logic [EXP_CNT_W-1:0] ebit, ebit_next;
  logic esq, esq_next;
  kind_t kind, kind_next;

  // microprogram: returns op, a, b, dst for a pc
  // doubling: t0=x1*x1; t0=t0+t0+t0+t1 via m ; d = y1+y1
  // chord: t0 = y2-y1 ; d = x2-x1
  dp_cmd_t uop;
  always_comb begin
    uop = '0;
    uop.step = 1'b1;
    case (pc)
      5'd0:  begin uop.op = OP_MUL; uop.src_a = SRC_X1; uop.src_b = SRC_X1; uop.dst = DST_T0; end
      5'd1:  begin uop.op = OP_ADD; uop.src_a = SRC_T0; uop.src_b = SRC_T0; uop.dst = DST_M; end
      5'd2:  begin uop.op = OP_ADD; uop.src_a = SRC_M;  uop.src_b = SRC_T0; uop.dst = DST_M; end
      5'd3:  begin uop.op = OP_ADD; uop.src_a = SRC_M;  uop.src_b = SRC_T1; uop.dst = DST_T0; end
      5'd4:  begin uop.op = OP_ADD; uop.src_a = SRC_Y1; uop.src_b = SRC_Y1; uop.dst = DST_M; end
      5'd8:  begin uop.op = OP_SUB; uop.src_a = SRC_Y2; uop.src_b = SRC_Y1; uop.dst = DST_T0; end
      5'd9:  begin uop.op = OP_SUB; uop.src_a = SRC_X2; uop.src_b = SRC_X1; uop.dst = DST_M; end
      // after inversion: r = 1/d
      5'd16: begin uop.op = OP_MUL; uop.src_a = SRC_T0; uop.src_b = SRC_R;  uop.dst = DST_M; end
      5'd17: begin uop.op = OP_MUL; uop.src_a = SRC_M;  uop.src_b = SRC_M;  uop.dst = DST_T0; end
      5'd18: begin uop.op = OP_SUB; uop.src_a = SRC_T0; uop.src_b = SRC_X1; uop.dst = DST_T0; end
      5'd19: begin uop.op = OP_SUB; uop.src_a = SRC_T0; uop.src_b = SRC_X2; uop.dst = DST_T0; end
      // t0 now holds x3
      5'd20: begin
        uop.op = OP_ADD; uop.src_a = SRC_T0; uop.src_b = SRC_ZERO; uop.dst = DST_X3;
      end
      5'd21: begin uop.op = OP_SUB; uop.src_a = SRC_X1; uop.src_b = SRC_T0; uop.dst = DST_T1; end
      5'd22: begin uop.op = OP_MUL; uop.src_a = SRC_M;  uop.src_b = SRC_T1; uop.dst = DST_T1; end
      5'd23: begin uop.op = OP_SUB; uop.src_a = SRC_T1; uop.src_b = SRC_Y1; uop.dst = DST_Y3; end
      default: uop.step = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    pc_next = pc;
    ebit_next = ebit;
    esq_next = esq;
    kind_next = kind;
    cmd = '0;
    fin = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        state_next = S_FIN;
        if (stat.inf1) kind_next = K_Q;
        else if (stat.inf2) kind_next = K_P;
        else if (stat.x_eq && !stat.y_dbl_ok) kind_next = K_INF;
        else begin
          kind_next = K_CALC;
          pc_next = stat.x_eq ? 5'd0 : 5'd8;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        cmd = uop;
        if (stat.done) begin
          if (pc == 5'd4 || pc == 5'd9) begin
            state_next = S_EXP;
            cmd.r_one = 1'b1;
            ebit_next = '0;
            esq_next = 1'b0;
          end else if (pc == 5'd23) begin
            state_next = S_FIN;
          end else begin
            pc_next = pc + 5'd1;
          end
        end
      end
      S_EXP: begin
        // left-to-right square and multiply over the bits of p-2; base sits in m
        cmd.step = 1'b1;
        cmd.op = OP_MUL;
        cmd.src_a = SRC_R;
        cmd.src_b = esq ? SRC_M : SRC_R;
        cmd.dst = DST_R;
        if (stat.done) begin
          if (!esq && INV_EXP[EXP_CNT_W'(FW-1) - ebit]) esq_next = 1'b1;
          else begin
            esq_next = 1'b0;
            if (ebit == EXP_CNT_W'(FW - 1)) begin
              state_next = S_RUN;
              pc_next = 5'd16;
            end else ebit_next = ebit + 1'b1;
          end
        end
      end
      S_FIN: begin
        fin = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc <= '0;
      ebit <= '0;
      esq <= 1'b0;
      kind <= K_CALC;
    end else begin
      state <= state_next;
      pc <= pc_next;
      ebit <= ebit_next;
      esq <= esq_next;
      kind <= kind_next;
    end
  end

  assign busy = state != S_IDLE;
  assign fin_kind = kind;
endmodule

/* hdl/ec_point_add_mersenne.sv */
// An addition runs 16 field multiplies, a doubling 17; no field arithmetic is run when
// an operand or the sum is at infinity. One item at a time: start is taken only while
// busy is low; busy drops in the result cycle.
// Synchronous reset returns to idle and sets curve_a to 4; result strobe cannot be stalled.
module ec_point_add_mersenne
  import ecpa_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [FW-1:0] p_x,
  input  logic [FW-1:0] p_y,
  input  logic          p_at_infinity,
  input  logic [FW-1:0] q_x,
  input  logic [FW-1:0] q_y,
  input  logic          q_at_infinity,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [FW-1:0] cfg_data,
  output logic          done,
  output logic [FW-1:0] sum_x,
  output logic [FW-1:0] sum_y,
  output logic          sum_at_infinity
);
  dp_cmd_t cmd;
  dp_stat_t stat;
  logic [FW-1:0] curve_a, x1, y1, x2, y2, x3, y3;
  logic fin;
  kind_t kind;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) curve_a <= FW'(4);
    else if (cfg_valid && cfg_ready) curve_a <= canon(cfg_data);
  end

  ecpa_ctrl u_ctrl (
    .clk, .rst, .start, .stat, .cmd, .busy, .fin, .fin_kind(kind)
  );

  ecpa_datapath u_dp (
    .clk, .cmd, .p_x, .p_y, .p_at_infinity, .q_x, .q_y, .q_at_infinity,
    .curve_a, .stat, .x1_o(x1), .y1_o(y1), .x2_o(x2), .y2_o(y2),
    .x3_o(x3), .y3_o(y3)
  );

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= fin;
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      case (kind)
        K_P: begin sum_x <= x1; sum_y <= y1; sum_at_infinity <= 1'b0; end
        K_Q: begin
          sum_x <= stat.inf2 ? '0 : x2;
          sum_y <= stat.inf2 ? '0 : y2;
          sum_at_infinity <= stat.inf2;
        end
        K_INF: begin sum_x <= '0; sum_y <= '0; sum_at_infinity <= 1'b1; end
        default: begin sum_x <= x3; sum_y <= y3; sum_at_infinity <= 1'b0; end
      endcase
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without work");
  a_inf_zero: assert property (@(posedge clk) disable iff (rst)
    (done && sum_at_infinity) |-> (sum_x == '0 && sum_y == '0))
    else $error("infinity with nonzero coordinates");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("start not taken");
endmodule

/* test/ec_point_add_mersenne_tb.sv */
`timescale 1ns / 100ps

module ec_point_add_mersenne_tb;
  import ecpa_pkg::*;

  typedef struct {
    logic [FW-1:0] x;
    logic [FW-1:0] y;
    logic          inf;
  } point_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  logic [FW-1:0] p_x = '0, p_y = '0, q_x = '0, q_y = '0;
  logic          p_at_infinity = 1'b0, q_at_infinity = 1'b0;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [FW-1:0] cfg_data = '0;
  logic          done;
  logic [FW-1:0] sum_x, sum_y;
  logic          sum_at_infinity;

  point_t        sum_queue[$];
  logic [FW-1:0] model_a = FW'(4);
  int            errors = 0;
  int            send_idle_pct = 0;

  ec_point_add_mersenne dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .p_x(p_x), .p_y(p_y), .p_at_infinity(p_at_infinity),
    .q_x(q_x), .q_y(q_y), .q_at_infinity(q_at_infinity),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .sum_x(sum_x), .sum_y(sum_y), .sum_at_infinity(sum_at_infinity)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [FW-1:0] fld_red(input logic [63:0] t);
    logic [63:0] prime;
    prime = 64'(PRIME);
    while (t > prime) t = (t & prime) + (t >> FW);
    if (t == prime) t = '0;
    return t[FW-1:0];
  endfunction

  function automatic logic [FW-1:0] fld_mul(input logic [FW-1:0] a, input logic [FW-1:0] b);
    return fld_red(64'(a) * 64'(b));
  endfunction

  function automatic logic [FW-1:0] fld_sub(input logic [FW-1:0] a, input logic [FW-1:0] b);
    return fld_red(64'(a) + 64'(PRIME) - 64'(b));
  endfunction

  function automatic logic [FW-1:0] fld_inv(input logic [FW-1:0] d);
    logic [63:0]   e;
    logic [FW-1:0] r;
    e = 64'(PRIME) - 64'(2);
    r = FW'(1);
    while (e != 0) begin
      if (e[0]) r = fld_mul(r, d);
      d = fld_mul(d, d);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic point_t point_sum(input point_t p, input point_t q);
    point_t        s;
    logic [FW-1:0] x1, y1, x2, y2, m, x3;
    x1 = fld_red(64'(p.x)); y1 = fld_red(64'(p.y));
    x2 = fld_red(64'(q.x)); y2 = fld_red(64'(q.y));
    s.x = '0; s.y = '0; s.inf = 1'b1;
    if (p.inf) begin
      if (!q.inf) begin s.x = x2; s.y = y2; s.inf = 1'b0; end
      return s;
    end
    if (q.inf) begin s.x = x1; s.y = y1; s.inf = 1'b0; return s; end
    if (x1 == x2) begin
      if (fld_red(64'(y1) + 64'(y2)) == 0 || y1 != y2) return s;
      m = fld_red(64'(fld_mul(FW'(3), fld_mul(x1, x1))) + 64'(fld_red(64'(model_a))));
      m = fld_mul(m, fld_inv(fld_mul(FW'(2), y1)));
    end else begin
      m = fld_mul(fld_sub(y2, y1), fld_inv(fld_sub(x2, x1)));
    end
    x3 = fld_sub(fld_sub(fld_mul(m, m), x1), x2);
    s.x = x3;
    s.y = fld_sub(fld_mul(m, fld_sub(x1, x3)), y1);
    s.inf = 1'b0;
    return s;
  endfunction

  // result checker: done may come on any cycle
  always @(posedge clk) begin
    point_t e;
    if (!rst && done) begin
      if (sum_queue.size() == 0) begin
        $error("unexpected result x=%0d y=%0d inf=%0b", sum_x, sum_y, sum_at_infinity);
        errors++;
      end else begin
        e = sum_queue.pop_front();
        if (sum_x !== e.x) begin $error("sum_x exp %0d got %0d", e.x, sum_x); errors++; end
        if (sum_y !== e.y) begin $error("sum_y exp %0d got %0d", e.y, sum_y); errors++; end
        if (sum_at_infinity !== e.inf) begin
          $error("sum_at_infinity exp %0b got %0b", e.inf, sum_at_infinity);
          errors++;
        end
      end
    end
  end

  task automatic send_add(input point_t p, input point_t q);
    @(posedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk);
    start <= 1'b1;
    p_x <= p.x; p_y <= p.y; p_at_infinity <= p.inf;
    q_x <= q.x; q_y <= q.y; q_at_infinity <= q.inf;
    @(posedge clk);
    while (busy) @(posedge clk);
    // word accepted at this edge
    sum_queue.push_back(point_sum(p, q));
    start <= 1'b0;
  endtask

  task automatic drain();
    while (sum_queue.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_curve_a(input logic [FW-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    model_a = fld_red(64'(v));
  endtask

  function automatic point_t mk(input int x, input int y, input bit inf);
    point_t r;
    r.x = FW'(x); r.y = FW'(y); r.inf = inf;
    return r;
  endfunction

  function automatic point_t rnd_pt();
    return mk($urandom_range(int'(PRIME)), $urandom_range(int'(PRIME)), $urandom_range(9) == 0);
  endfunction

  task automatic test_directed();
    int mx;
    mx = int'(PRIME);
    send_add(mk(3, 5, 1), mk(9, 11, 1));
    send_add(mk(3, 5, 1), mk(9, 11, 0));
    send_add(mk(mx, mx, 1), mk(mx, mx, 0));
    send_add(mk(7, 8, 0), mk(1, 2, 1));
    send_add(mk(mx, 8, 0), mk(mx - 1, 2, 1));
    send_add(mk(10, 20, 0), mk(10, mx - 20, 0));
    send_add(mk(10, 0, 0), mk(10, 0, 0));
    send_add(mk(10, mx, 0), mk(10, 0, 0));
    send_add(mk(10, 20, 0), mk(10, 33, 0));
    send_add(mk(10, 20, 0), mk(10, 20, 0));
    send_add(mk(0, 1, 0), mk(0, 1, 0));
    send_add(mk(mx - 1, mx - 1, 0), mk(mx - 1, mx - 1, 0));
    send_add(mk(5, 20, 0), mk(40, mx - 20, 0));
    send_add(mk(0, 0, 0), mk(mx - 1, mx - 1, 0));
    send_add(mk(mx, 3, 0), mk(0, 3, 0));
    send_add(mk(1, 2, 0), mk(3, 4, 0));
  endtask

  task automatic test_curve_a_extremes();
    point_t p;
    logic [FW-1:0] vals[4];
    vals = '{'0, PRIME - FW'(1), PRIME, FW'(4)};
    foreach (vals[i]) begin
      write_curve_a(vals[i]);
      repeat (6) begin
        p = rnd_pt();
        p.inf = 1'b0;
        send_add(p, p);
      end
    end
  endtask

  task automatic test_random(input int count);
    point_t p, q;
    repeat (count) begin
      p = rnd_pt();
      q = rnd_pt();
      case ($urandom_range(3))
        0: q = p;
        1: begin q.x = p.x; q.y = fld_sub('0, fld_red(64'(p.y))); end
        default: ;
      endcase
      send_add(p, q);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_curve_a_extremes();
    send_idle_pct = 27;
    test_random(230);
    drain(); // hold off until every result is in
    write_curve_a(FW'($urandom_range(int'(PRIME))));
    send_idle_pct = 47;
    test_random(230);
    write_curve_a(FW'($urandom_range(int'(PRIME))));
    send_idle_pct = 0;
    test_random(230);
    drain();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
